@@ hdl/topk_pkg.sv @@
// Shared types and constants for the top-K min-heap filter.
// Holds the request, response and heap entry structs used by the top level and its checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package topk_pkg;

  localparam int ScoreBits = 32;
  localparam int IndexBits = 24;
  localparam int CountBits = 11;
  localparam int LimitBits = 11;

  localparam logic [LimitBits-1:0] LimitReset = 11'd50;

  // Request codes carried in req_type.
  localparam logic ReqOffer = 1'b0;
  localparam logic ReqClear = 1'b1;

  typedef struct packed {
    logic                        req_type;
    logic signed [ScoreBits-1:0] candidate_score;
    logic [IndexBits-1:0]        candidate_start;
    logic [IndexBits-1:0]        candidate_end;
  } topk_req_t;

  typedef struct packed {
    logic                        accepted;
    logic                        evicted_valid;
    logic signed [ScoreBits-1:0] evicted_score;
    logic [IndexBits-1:0]        evicted_start;
    logic [IndexBits-1:0]        evicted_end;
    logic [CountBits-1:0]        fill_count;
    logic signed [ScoreBits-1:0] min_score;
  } topk_rsp_t;

  typedef struct packed {
    logic signed [ScoreBits-1:0] score;
    logic [IndexBits-1:0]        seg_start;
    logic [IndexBits-1:0]        seg_end;
  } topk_entry_t;

endpackage

`default_nettype wire

@@ hdl/top_k_min_heap_filter_unit.sv @@
// Top-K selection filter: keeps the highest-scoring segments in a binary min-heap.
// The heap lives in one synchronous memory with one write port and two read ports.
// Depends on topk_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Each transaction on the input channel produces exactly one response. A clear or a rejected
// offer goes from the decide state straight to the response. An insert while the heap is not
// full sifts the new entry up from the next free position; a replacement of the root first
// pulls the last entry up and sifts it down from the root, then inserts the offer the same way.
// Each heap level walked takes a registered read of the parent (sift-up) or of both children
// (sift-down) and the write-back of the displaced entry. The limit register may be written at
// any time the unit is idle; the heap memory needs no clearing after reset.
module top_k_min_heap_filter_unit #(
  parameter int HEAP_DEPTH = 1024
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire topk_pkg::topk_req_t              in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output topk_pkg::topk_rsp_t                   out_data_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [topk_pkg::LimitBits-1:0]   cfg_data_i
);

  import topk_pkg::*;

  localparam int PW = $clog2(HEAP_DEPTH + 1);
  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int RW = PW + 2;
  localparam int LW = (PW > LimitBits) ? PW : LimitBits;

  localparam logic [3:0] StIdle      = 4'd0;
  localparam logic [3:0] StDecide    = 4'd1;
  localparam logic [3:0] StIns       = 4'd2;
  localparam logic [3:0] StUp        = 4'd3;
  localparam logic [3:0] StUpPlace   = 4'd4;
  localparam logic [3:0] StLast      = 4'd5;
  localparam logic [3:0] StDown      = 4'd6;
  localparam logic [3:0] StDownPlace = 4'd7;
  localparam logic [3:0] StResp      = 4'd8;

  logic [3:0]           state_q, state_d;
  logic [PW-1:0]        count_q, count_d;
  logic [PW-1:0]        pos_q, pos_d;
  logic [LimitBits-1:0] limit_q;
  topk_req_t            item_q, item_d;
  topk_entry_t          x_q, x_d;
  topk_entry_t          evict_q, evict_d;
  topk_entry_t          root_q;
  logic                 acc_q, acc_d;
  logic                 ev_q, ev_d;
  logic                 out_valid_q, out_valid_d;
  topk_rsp_t            out_q, out_d;

  topk_entry_t          mem_q [HEAP_DEPTH];
  topk_entry_t          rd_a_q, rd_b_q;
  logic                 wr_en, rd_en;
  logic [PW-1:0]        wr_pos;
  topk_entry_t          wr_data;
  logic [RW-1:0]        rd_pos_a, rd_pos_b;
  logic [AW-1:0]        wr_addr, rd_addr_a, rd_addr_b;

  topk_entry_t          item_entry;
  logic [LW-1:0]        lim_eff;
  logic [PW-1:0]        ins_pos;
  logic [PW-1:0]        par_pos;
  logic [PW:0]          left_pos, son_pos;
  logic [PW+1:0]        grand_pos;
  logic                 has_right, take_right;
  topk_entry_t          son_e;

  assign item_entry = '{score:     item_q.candidate_score,
                        seg_start: item_q.candidate_start,
                        seg_end:   item_q.candidate_end};

  // A limit of zero behaves as one, and a limit above the depth saturates.
  always_comb begin
    lim_eff = (limit_q == '0) ? LW'(1) : LW'(limit_q);
    if (lim_eff > LW'(HEAP_DEPTH)) begin
      lim_eff = LW'(HEAP_DEPTH);
    end
  end

  assign ins_pos    = count_q + PW'(1);
  assign par_pos    = pos_q >> 1;
  assign left_pos   = {pos_q, 1'b0};
  assign has_right  = (left_pos + (PW+1)'(1)) <= (PW+1)'(count_q);
  assign take_right = has_right && ($signed(rd_b_q.score) < $signed(rd_a_q.score));
  assign son_pos    = take_right ? (left_pos + (PW+1)'(1)) : left_pos;
  assign son_e      = take_right ? rd_b_q : rd_a_q;
  assign grand_pos  = {son_pos, 1'b0};

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    x_d         = x_q;
    evict_d     = evict_q;
    acc_d       = acc_q;
    ev_d        = ev_q;
    item_d      = item_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    wr_en       = 1'b0;
    wr_pos      = pos_q;
    wr_data     = item_entry;
    rd_en       = 1'b0;
    rd_pos_a    = RW'(pos_q);
    rd_pos_b    = RW'(pos_q);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          state_d = StDecide;
        end
      end
      StDecide: begin
        acc_d = 1'b0;
        ev_d  = 1'b0;
        if (item_q.req_type == ReqClear) begin
          count_d = '0;
          state_d = StResp;
        end else if (LW'(count_q) < lim_eff) begin
          acc_d   = 1'b1;
          state_d = StIns;
        end else if ($signed(item_q.candidate_score) > $signed(root_q.score)) begin
          // Full: evict the root, pull the last entry up for the sift-down.
          acc_d    = 1'b1;
          ev_d     = 1'b1;
          evict_d  = root_q;
          rd_en    = 1'b1;
          rd_pos_a = RW'(count_q);
          count_d  = count_q - PW'(1);
          state_d  = StLast;
        end else begin
          state_d = StResp;
        end
      end
      StIns: begin
        count_d = ins_pos;
        pos_d   = ins_pos;
        if (count_q == '0) begin
          wr_en   = 1'b1;
          wr_pos  = PW'(1);
          wr_data = item_entry;
          state_d = StResp;
        end else begin
          rd_en    = 1'b1;
          rd_pos_a = RW'(ins_pos >> 1);
          state_d  = StUp;
        end
      end
      StUp: begin
        wr_en  = 1'b1;
        wr_pos = pos_q;
        if ($signed(rd_a_q.score) > $signed(item_q.candidate_score)) begin
          wr_data = rd_a_q;
          pos_d   = par_pos;
          if (par_pos > PW'(1)) begin
            rd_en    = 1'b1;
            rd_pos_a = RW'(par_pos >> 1);
          end else begin
            state_d = StUpPlace;
          end
        end else begin
          wr_data = item_entry;
          state_d = StResp;
        end
      end
      StUpPlace: begin
        wr_en   = 1'b1;
        wr_pos  = pos_q;
        wr_data = item_entry;
        state_d = StResp;
      end
      StLast: begin
        x_d   = rd_a_q;
        pos_d = PW'(1);
        if (count_q >= PW'(2)) begin
          rd_en    = 1'b1;
          rd_pos_a = RW'(2);
          rd_pos_b = RW'(3);
          state_d  = StDown;
        end else begin
          state_d = StDownPlace;
        end
      end
      StDown: begin
        wr_en  = 1'b1;
        wr_pos = pos_q;
        if ($signed(son_e.score) < $signed(x_q.score)) begin
          wr_data = son_e;
          pos_d   = son_pos[PW-1:0];
          if (grand_pos <= (PW+2)'(count_q)) begin
            rd_en    = 1'b1;
            rd_pos_a = RW'(grand_pos);
            rd_pos_b = RW'(grand_pos) + RW'(1);
          end else begin
            state_d = StDownPlace;
          end
        end else begin
          wr_data = x_q;
          state_d = StIns;
        end
      end
      StDownPlace: begin
        wr_en   = 1'b1;
        wr_pos  = pos_q;
        wr_data = x_q;
        state_d = StIns;
      end
      StResp: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d         = 1'b1;
          out_d.accepted      = acc_q;
          out_d.evicted_valid = ev_q;
          out_d.evicted_score = ev_q ? evict_q.score : '0;
          out_d.evicted_start = ev_q ? evict_q.seg_start : '0;
          out_d.evicted_end   = ev_q ? evict_q.seg_end : '0;
          out_d.fill_count    = CountBits'(count_q);
          out_d.min_score     = (count_q != '0) ? root_q.score : '0;
          state_d             = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Heap positions count from one; memory addresses from zero.
  assign wr_addr   = AW'(RW'(wr_pos) - RW'(1));
  assign rd_addr_a = AW'(rd_pos_a - RW'(1));
  assign rd_addr_b = AW'(rd_pos_b - RW'(1));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_q <= mem_q[rd_addr_a];
      rd_b_q <= mem_q[rd_addr_b];
    end
  end

  // A copy of the root follows every write to the top of the heap.
  always_ff @(posedge clk_i) begin
    if (wr_en && (wr_pos == PW'(1))) begin
      root_q <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      limit_q     <= LimitReset;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    pos_q   <= pos_d;
    x_q     <= x_d;
    evict_q <= evict_d;
    acc_q   <= acc_d;
    ev_q    <= ev_d;
    out_q   <= out_d;
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

endmodule

`default_nettype wire

@@ hdl/topk_checker.sv @@
// Port-level checker for the top-K min-heap filter, bound to the top level.
// Depends on topk_pkg and top_k_min_heap_filter_unit.
`timescale 1ns / 1ps
`default_nettype none

module topk_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire topk_pkg::topk_req_t in_data_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire topk_pkg::topk_rsp_t out_data_o
);

  import topk_pkg::*;

  // A stalled input transaction must hold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input transaction changed while stalled");

  // A stalled response must hold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("response changed while stalled");

  // An eviction only happens to make room for an accepted offer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.evicted_valid |-> out_data_o.accepted)
    else $error("eviction without acceptance");

  // Without an eviction the evicted fields read as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.evicted_valid |->
      (out_data_o.evicted_score == '0) && (out_data_o.evicted_start == '0) &&
      (out_data_o.evicted_end == '0))
    else $error("evicted fields not zero");

  // An empty heap reports a zero minimum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.fill_count == '0) |-> out_data_o.min_score == '0)
    else $error("nonzero minimum on empty heap");

endmodule

bind top_k_min_heap_filter_unit topk_checker u_topk_checker (.*);

`default_nettype wire

@@ verif/topk_scoreboard_pkg.sv @@
// Scoreboard for the top-K min-heap filter: a bit-exact heap predictor and a response checker.
// Depends on topk_pkg for the request, response and entry structs.
`timescale 1ns / 1ps

package topk_scoreboard_pkg;
  import topk_pkg::*;

  localparam int HeapDepth = 1024;

  class topk_scoreboard;
    topk_entry_t          slots[1:HeapDepth];
    int unsigned          held;
    logic [LimitBits-1:0] limit_reg;
    topk_rsp_t            expected_q[$];
    int unsigned          error_count;

    function new();
      held        = 0;
      limit_reg   = LimitReset;
      error_count = 0;
    endfunction

    function void set_limit(logic [LimitBits-1:0] value);
      limit_reg = value;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void sift_up(topk_entry_t item);
      int unsigned pos;
      if (held >= HeapDepth) return;
      held++;
      pos = held;
      while (pos > 1 && slots[pos >> 1].score > item.score) begin
        slots[pos] = slots[pos >> 1];
        pos = pos >> 1;
      end
      slots[pos] = item;
    endfunction

    // The right child wins only when strictly smaller than the left one.
    function void drop_root();
      topk_entry_t swap_tmp;
      int unsigned pos;
      int unsigned kid;
      pos = 1;
      if (held == 0) return;
      slots[1] = slots[held];
      held--;
      while (2 * pos <= held) begin
        kid = 2 * pos;
        if (kid + 1 <= held && slots[kid + 1].score < slots[kid].score) kid++;
        if (slots[kid].score >= slots[pos].score) break;
        swap_tmp    = slots[kid];
        slots[kid]  = slots[pos];
        slots[pos]  = swap_tmp;
        pos = kid;
      end
    endfunction

    function void note_request(topk_req_t req);
      topk_rsp_t   rsp;
      topk_entry_t item;
      int unsigned cap;
      rsp            = '0;
      item.score     = req.candidate_score;
      item.seg_start = req.candidate_start;
      item.seg_end   = req.candidate_end;
      cap = (limit_reg == 0) ? 1 : limit_reg;
      if (cap > HeapDepth) cap = HeapDepth;
      if (req.req_type == ReqClear) begin
        held = 0;
      end else if (held < cap) begin
        sift_up(item);
        rsp.accepted = 1'b1;
      end else if (req.candidate_score > slots[1].score) begin
        rsp.accepted      = 1'b1;
        rsp.evicted_valid = 1'b1;
        rsp.evicted_score = slots[1].score;
        rsp.evicted_start = slots[1].seg_start;
        rsp.evicted_end   = slots[1].seg_end;
        drop_root();
        sift_up(item);
      end
      rsp.fill_count = CountBits'(held);
      rsp.min_score  = (held > 0) ? slots[1].score : '0;
      expected_q.push_back(rsp);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        error_count++;
        $display("%0t ns: %s expected %0h, got %0h", $time, field, want, seen);
      end
    endfunction

    function void check_response(topk_rsp_t got);
      topk_rsp_t want;
      if (expected_q.size() == 0) begin
        error_count++;
        $display("%0t ns: response with no request outstanding, got %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      compare("accepted", want.accepted, got.accepted);
      compare("evicted_valid", want.evicted_valid, got.evicted_valid);
      compare("evicted_score", want.evicted_score, got.evicted_score);
      compare("evicted_start", want.evicted_start, got.evicted_start);
      compare("evicted_end", want.evicted_end, got.evicted_end);
      compare("fill_count", want.fill_count, got.fill_count);
      compare("min_score", want.min_score, got.min_score);
    endfunction
  endclass

endpackage

@@ verif/tb_top.sv @@
// Testbench top for top_k_min_heap_filter_unit: drives offers, clears and limit writes
// with random idling on the request and response channels and checks each response against the scoreboard.
// Depends on topk_pkg and topk_scoreboard_pkg.
`timescale 1ns / 1ps

module tb_top;
  import topk_pkg::*;
  import topk_scoreboard_pkg::*;

  logic                 clk;
  logic                 rst_ni;
  logic                 in_valid;
  logic                 in_ready;
  topk_req_t            in_data;
  logic                 out_valid;
  logic                 out_ready;
  topk_rsp_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [LimitBits-1:0] cfg_data;

  topk_scoreboard board;
  bit             quiet;
  bit             long_hold;

  top_k_min_heap_filter_unit #(
    .HEAP_DEPTH(HeapDepth)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Each transaction on the request channel is noted in the scoreboard once it is accepted.
  task automatic send_request(input topk_req_t req);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(req);
    @(negedge clk);
  endtask

  task automatic offer(input logic [31:0] score, input logic [23:0] seg_start,
                       input logic [23:0] seg_end);
    topk_req_t req;
    req.req_type        = ReqOffer;
    req.candidate_score = score;
    req.candidate_start = seg_start;
    req.candidate_end   = seg_end;
    send_request(req);
  endtask

  task automatic clear_heap();
    topk_req_t req;
    req.req_type        = ReqClear;
    req.candidate_score = $urandom;
    req.candidate_start = 24'($urandom_range(0, 24'hFFFFFF));
    req.candidate_end   = 24'($urandom_range(0, 24'hFFFFFF));
    send_request(req);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(input logic [LimitBits-1:0] value);
    drain();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_limit(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Scores lean toward the extremes and a narrow band so that ties with the root are common.
  function automatic logic [31:0] pick_score();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2: return 32'($signed($urandom_range(0, 8)) - 4);
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random(input int count, input int clear_odds);
    for (int i = 0; i < count; i++) begin
      if (clear_odds > 0 && $urandom_range(0, clear_odds - 1) == 0) begin
        clear_heap();
      end else begin
        offer(pick_score(), 24'($urandom_range(0, 24'hFFFFFF)),
              24'($urandom_range(0, 24'hFFFFFF)));
      end
    end
  endtask

  // Response side: random stall before each transaction, or one long stall on request.
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        stall = 300;
      end else begin
        stall = quiet ? 0 : $urandom_range(0, 14);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      board.check_response(out_data);
      @(negedge clk);
    end
  end

  initial begin
    board     = new();
    quiet     = 1'b0;
    long_hold = 1'b0;
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (5) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    // Reset limit: extreme scores and indices, then clears on a heap of five entries and on an empty heap.
    offer(32'h8000_0000, 24'h000000, 24'hFFFFFF);
    offer(32'h7FFF_FFFF, 24'hFFFFFF, 24'h000000);
    offer(32'h0000_0000, 24'h000001, 24'h000002);
    offer(32'hFFFF_FFFF, 24'h800000, 24'h7FFFFF);
    offer(32'h0000_0001, 24'h123456, 24'hABCDEF);
    clear_heap();
    clear_heap();

    // A limit of zero keeps a single entry; equal scores are turned away.
    write_limit(11'd0);
    offer(32'd5, 24'd10, 24'd20);
    offer(32'd5, 24'd11, 24'd21);
    offer(32'd4, 24'd12, 24'd22);
    offer(32'd6, 24'd13, 24'd23);
    offer(32'h7FFF_FFFF, 24'd14, 24'd24);
    offer(32'h7FFF_FFFF, 24'd15, 24'd25);
    offer(32'h8000_0000, 24'd16, 24'd26);
    clear_heap();

    write_limit(11'd2);
    offer(32'd3, 24'd30, 24'd31);
    offer(32'd3, 24'd32, 24'd33);
    offer(32'd3, 24'd34, 24'd35);
    offer(32'd7, 24'd36, 24'd37);
    offer(32'd7, 24'd38, 24'd39);
    clear_heap();
    run_random(60, 15);

    write_limit(11'd1);
    run_random(40, 12);

    write_limit(11'd50);
    run_random(60, 40);
    long_hold = 1'b1;
    run_random(60, 40);
    drain();
    run_random(40, 0);

    // The heap now holds more than the new limit, so accepted offers replace the root.
    write_limit(11'd5);
    run_random(40, 0);

    // A limit beyond the heap depth saturates; the first sixty offers follow each other without idling.
    write_limit(11'd2047);
    clear_heap();
    quiet = 1'b1;
    run_random(60, 0);
    quiet = 1'b0;
    run_random(30, 0);

    write_limit(11'd1024);
    run_random(40, 0);
    run_random(30, 25);

    write_limit(11'd3);
    run_random(50, 8);

    drain();
    repeat (40) @(negedge clk);
    if (board.error_count == 0 && board.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
